>>> design/sega_pkg.sv
`default_nettype none
package sega_pkg;
  localparam int ACTION_W = 1;
  localparam int SIZE_W   = 21;
  localparam int STATUS_W = 3;
  localparam int POLICY_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC = 3'd0,
    ST_NOFIT = 3'd1,
    ST_FREED = 3'd2,
    ST_NOID  = 3'd3,
    ST_FULL  = 3'd4
  } status_t;

  localparam logic [POLICY_W-1:0] POL_WORST = 2'd1;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd2;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_TOTAL  = 1'b1;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // scan unit control
  typedef struct packed {
    logic start;
    logic mode_release;
  } scan_ctl_t;
endpackage
`default_nettype wire

>>> design/segment_allocator_fit_policy.sv
`default_nettype none
// Contiguous segment allocator with first / worst / best fit.
// in_ channel: one request word; tdata = {request_size, process_id, action}.
// out_ channel: one result word per request; tdata = {free_total,
// segment_size, base_address, status}.
// cfg_ port: index 0 fit_policy, index 1 total_memory (rebuilds the table).
// A request is accepted, then the table is scanned (first fit and release
// stop at the first match) and the chosen entry is read. A split then moves
// the entries above the hole up, a read and then a write per entry; a release
// moves entries down by the same means for each merged neighbour, up to twice.
// in_tready is low while a request is at work. The result is held in an
// output register until out_tready, and the next request may be taken
// meanwhile; a receiver stall only holds the block once that next result
// is ready too. After reset the table is one free hole of 1 << ADDRESS_BITS.
module segment_allocator_fit_policy #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDRESS_BITS = 20,
  parameter int ID_BITS      = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  // action, process_id, request_size; zero padded
  input  wire [((1+ID_BITS+ADDRESS_BITS+1+7)/8)*8-1:0] in_tdata,
  output logic       out_tvalid,
  input  wire        out_tready,
  // status, base_address, segment_size, free_total; zero padded
  output logic [((3+3*ADDRESS_BITS+2+7)/8)*8-1:0] out_tdata,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [ADDRESS_BITS:0] cfg_wdata
);
  import sega_pkg::*;

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int LEN_W = ADDRESS_BITS + 1;
  localparam int OUT_W = ((3+3*ADDRESS_BITS+2+7)/8)*8;
  localparam logic [LEN_W-1:0] MEM_LIMIT = {1'b1, {ADDRESS_BITS{1'b0}}};
  localparam logic [IDX_W:0] MAXS = (IDX_W+1)'(MAX_SEGMENTS);
  // marks a release whose lower merge already ran
  localparam logic [STATUS_W-1:0] ST_DONE_MARK = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_WAIT, S_RDH, S_DEC, S_SHUP, S_SPLIT,
    S_RDN, S_MRGN, S_RDP, S_MRGP, S_SHDN, S_OUT
  } state_t;

  // table: one read port and one write port
  logic [ADDRESS_BITS-1:0] base_mem [MAX_SEGMENTS];
  logic [LEN_W-1:0]        len_mem  [MAX_SEGMENTS];
  logic [ID_BITS-1:0]      own_mem  [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] free_r;

  logic [IDX_W-1:0]        ra;
  logic [ADDRESS_BITS-1:0] rb_r;
  logic [LEN_W-1:0]        rl_r;
  logic [ID_BITS-1:0]      ro_r;
  logic                    rf_r;
  logic                    we;
  logic [IDX_W-1:0]        wa;
  logic [ADDRESS_BITS-1:0] wb;
  logic [LEN_W-1:0]        wl;
  logic [ID_BITS-1:0]      wo;
  logic                    wf;

  state_t state_r, state_nxt;
  logic [1:0]        policy_r;
  logic [LEN_W-1:0]  free_mem_r, free_mem_nxt;
  logic [IDX_W:0]    count_r, count_nxt;
  logic              act_r;
  logic [ID_BITS-1:0] id_r;
  logic [LEN_W-1:0]  size_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W:0]    sh_r, sh_nxt;
  logic              sh_ph_r, sh_ph_nxt;
  logic [LEN_W-1:0]  acc_r, acc_nxt;
  logic [ADDRESS_BITS-1:0] hb_r, hb_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [ADDRESS_BITS-1:0] ob_r, ob_nxt;
  logic [LEN_W-1:0]  ol_r, ol_nxt;
  logic              ov_r, ov_nxt;
  logic [OUT_W-1:0]  od_r, od_nxt;
  logic              rebuild;
  logic [LEN_W-1:0]  cfg_tot;

  scan_ctl_t sctl;
  logic [IDX_W-1:0] s_idx;
  logic s_done, s_found;
  logic [IDX_W-1:0] s_pick;

  sega_scan #(.IDX_W(IDX_W), .LEN_W(LEN_W), .ID_W(ID_BITS)) u_scan (
    .clk, .rst_n, .ctl(sctl), .policy(policy_r), .want(size_r), .want_id(id_r),
    .count(count_r), .rd_idx(s_idx), .rd_len(rl_r), .rd_owner(ro_r),
    .rd_free(rf_r), .done(s_done), .found(s_found), .pick(s_pick)
  );

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign cfg_tot = (cfg_wdata > MEM_LIMIT) ? MEM_LIMIT : cfg_wdata;
  assign rebuild = cfg_we && cfg_index == CFG_TOTAL;

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; free_mem_nxt = free_mem_r;
    idx_nxt = idx_r; sh_nxt = sh_r; sh_ph_nxt = 1'b0; acc_nxt = acc_r;
    hb_nxt = hb_r; st_nxt = st_r; ob_nxt = ob_r; ol_nxt = ol_r; ov_nxt = ov_r;
    od_nxt = od_r;
    sctl = '0; ra = s_idx;
    we = 1'b0; wa = idx_r; wb = rb_r; wl = rl_r; wo = ro_r; wf = rf_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_acc) begin
        if (in_tdata[0] == ACT_ALLOC &&
            in_tdata[ID_BITS+ADDRESS_BITS+1:ID_BITS+1] == '0) begin
          st_nxt = ST_NOFIT; ob_nxt = '0; ol_nxt = '0; state_nxt = S_OUT;
        end else begin
          sctl.start = 1'b1; sctl.mode_release = in_tdata[0];
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: if (s_done) begin
        if (!s_found) begin
          st_nxt = act_r ? ST_NOID : ST_NOFIT; ob_nxt = '0; ol_nxt = '0;
          state_nxt = S_OUT;
        end else begin
          idx_nxt = s_pick; state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin ra = idx_r; state_nxt = S_RDH; end
      S_RDH: begin ra = idx_r; state_nxt = S_DEC; end
      S_DEC: begin
        ob_nxt = rb_r;
        if (act_r) begin
          ol_nxt = rl_r; acc_nxt = rl_r; hb_nxt = rb_r;
          free_mem_nxt = free_mem_r + rl_r; st_nxt = ST_FREED;
          we = 1'b1; wf = 1'b1; wo = '0;
          ra = idx_r + 1'b1;
          state_nxt = S_RDN;
        end else if (rl_r == size_r) begin
          we = 1'b1; wf = 1'b0; wo = id_r;
          ol_nxt = size_r; free_mem_nxt = free_mem_r - size_r; st_nxt = ST_ALLOC;
          state_nxt = S_OUT;
        end else if (count_r >= MAXS) begin
          st_nxt = ST_FULL; ob_nxt = '0; ol_nxt = '0; state_nxt = S_OUT;
        end else begin
          ol_nxt = size_r; free_mem_nxt = free_mem_r - size_r; st_nxt = ST_ALLOC;
          acc_nxt = rl_r; hb_nxt = rb_r;
          sh_nxt = count_r; state_nxt = S_SHUP;
        end
      end
      // move entries idx..count-1 up one: read k-1, then write k
      S_SHUP: begin
        if (sh_r == {1'b0, idx_r}) state_nxt = S_SPLIT;
        else if (!sh_ph_r) begin
          ra = IDX_W'(sh_r - 1'b1); sh_ph_nxt = 1'b1;
        end else if (sh_ph_r) begin
          ra = IDX_W'(sh_r - 1'b1);
          sh_ph_nxt = 1'b0;
          we = 1'b1; wa = sh_r[IDX_W-1:0];
          sh_nxt = sh_r - 1'b1;
        end
      end
      S_SPLIT: begin
        if (!sh_ph_r) begin
          we = 1'b1; wa = idx_r; wb = hb_r; wl = size_r; wo = id_r; wf = 1'b0;
          sh_ph_nxt = 1'b1;
        end else begin
          we = 1'b1; wa = idx_r + 1'b1; wb = hb_r + size_r[ADDRESS_BITS-1:0];
          wl = acc_r - size_r; wo = '0; wf = 1'b1;
          count_nxt = count_r + 1'b1; state_nxt = S_OUT;
        end
      end
      S_RDN: begin ra = idx_r + 1'b1; state_nxt = S_MRGN; end
      S_MRGN: begin
        if ({1'b0, idx_r} + 1'b1 < count_r && rf_r) begin
          acc_nxt = acc_r + rl_r;
          we = 1'b1; wa = idx_r; wb = hb_r; wl = acc_r + rl_r; wo = '0; wf = 1'b1;
          sh_nxt = {1'b0, idx_r} + 2'd2; count_nxt = count_r - 1'b1;
          // remove idx+1 by shifting down, then check the lower side
          state_nxt = S_SHDN;
          sh_ph_nxt = 1'b0;
        end else begin
          ra = idx_r - 1'b1; state_nxt = S_RDP;
        end
      end
      S_SHDN: begin
        if (sh_r > count_r) begin
          ra = idx_r - 1'b1;
          if (st_r == ST_DONE_MARK) state_nxt = S_OUT;
          else state_nxt = S_RDP;
        end else if (!sh_ph_r) begin
          ra = sh_r[IDX_W-1:0]; sh_ph_nxt = 1'b1;
        end else begin
          ra = sh_r[IDX_W-1:0];
          we = 1'b1; wa = IDX_W'(sh_r - 1'b1); sh_nxt = sh_r + 1'b1;
        end
      end
      S_RDP: begin
        ra = idx_r - 1'b1;
        if (idx_r == '0) state_nxt = S_OUT;
        else state_nxt = S_MRGP;
      end
      S_MRGP: begin
        if (rf_r) begin
          we = 1'b1; wa = idx_r - 1'b1; wb = rb_r; wl = rl_r + acc_r;
          wo = '0; wf = 1'b1;
          count_nxt = count_r - 1'b1;
          sh_nxt = {1'b0, idx_r} + 1'b1; st_nxt = ST_DONE_MARK;
          state_nxt = S_SHDN;
        end else state_nxt = S_OUT;
      end
      // waits here only while the previous word is still unread
      S_OUT: begin
        if (!ov_r || out_tready) begin
          od_nxt = OUT_W'({free_mem_r, ol_r, ob_r,
                           (st_r == ST_DONE_MARK) ? ST_FREED : st_r});
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // reset and a new total both lay down one free hole at entry 0
    if (!rst_n || rebuild) begin
      we = 1'b1; wa = '0; wb = '0; wo = '0; wf = 1'b1;
      wl = rst_n ? cfg_tot : MEM_LIMIT;
      count_nxt = (IDX_W+1)'(1); free_mem_nxt = wl;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      base_mem[wa] <= wb; len_mem[wa] <= wl; own_mem[wa] <= wo;
    end
    rb_r <= base_mem[ra]; rl_r <= len_mem[ra]; ro_r <= own_mem[ra];
    rf_r <= free_r[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; policy_r <= '0;
      free_mem_r <= MEM_LIMIT; count_r <= (IDX_W+1)'(1); ov_r <= 1'b0;
      free_r <= MAX_SEGMENTS'(1); sh_ph_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; free_mem_r <= free_mem_nxt;
      ov_r <= ov_nxt; sh_ph_r <= sh_ph_nxt;
      if (we) free_r[wa] <= wf;
      if (cfg_we && cfg_index == CFG_POLICY) policy_r <= cfg_wdata[1:0];
    end
    if (in_acc) begin
      act_r <= in_tdata[0]; id_r <= in_tdata[ID_BITS:1];
      size_r <= in_tdata[ID_BITS+ADDRESS_BITS+1:ID_BITS+1];
    end
    idx_r <= idx_nxt; sh_r <= sh_nxt; acc_r <= acc_nxt; hb_r <= hb_nxt;
    st_r <= st_nxt; ob_r <= ob_nxt; ol_r <= ol_nxt; od_r <= od_nxt;
  end

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready busy");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAXS && count_r != '0) else $error("count range");
  a_free: assert property (@(posedge clk) disable iff (!rst_n)
    free_mem_r <= MEM_LIMIT) else $error("free overflow");
endmodule
`default_nettype wire

>>> design/sega_scan.sv
`default_nettype none
// Walks the table one entry per cycle, keeps the chosen hole or the
// first owned match.
module sega_scan #(
  parameter int IDX_W = 6,
  parameter int LEN_W = 21,
  parameter int ID_W  = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  sega_pkg::scan_ctl_t     ctl,
  input  wire [1:0]               policy,
  input  wire [LEN_W-1:0]         want,
  input  wire [ID_W-1:0]          want_id,
  input  wire [IDX_W:0]           count,
  output logic [IDX_W-1:0]        rd_idx,
  input  wire [LEN_W-1:0]         rd_len,
  input  wire [ID_W-1:0]          rd_owner,
  input  wire                     rd_free,
  output logic                    done,
  output logic                    found,
  output logic [IDX_W-1:0]        pick
);
  import sega_pkg::*;

  logic             busy_r, busy_nxt;
  logic             chk_r, chk_nxt;
  logic [IDX_W:0]   k_r, k_nxt;
  logic [IDX_W-1:0] ck_r, ck_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic [LEN_W-1:0] plen_r, plen_nxt;
  logic             done_r, done_nxt;
  logic             rel_r, rel_nxt;
  logic             cand, better, stop;

  assign rd_idx = k_r[IDX_W-1:0];
  assign done   = done_r;
  assign found  = found_r;
  assign pick   = pick_r;

  always_comb begin
    cand = rel_r ? (!rd_free && rd_owner == want_id)
                 : (rd_free && rd_len >= want);
    better = 1'b0;
    if (!found_r) better = 1'b1;
    else if (!rel_r && policy == POL_WORST) better = rd_len > plen_r;
    else if (!rel_r && policy == POL_BEST)  better = rd_len < plen_r;
    stop = rel_r || (policy != POL_WORST && policy != POL_BEST);
  end

  always_comb begin
    busy_nxt = busy_r; chk_nxt = 1'b0; k_nxt = k_r; ck_nxt = ck_r;
    found_nxt = found_r; pick_nxt = pick_r; plen_nxt = plen_r;
    done_nxt = 1'b0; rel_nxt = rel_r;
    if (ctl.start) begin
      busy_nxt = 1'b1; k_nxt = '0; found_nxt = 1'b0; rel_nxt = ctl.mode_release;
    end else if (busy_r) begin
      // read data arrives in the cycle after the address
      if (chk_r && cand && better) begin
        found_nxt = 1'b1; pick_nxt = ck_r; plen_nxt = rd_len;
      end
      if ((chk_r && cand && stop) || (!chk_r && k_r >= count && k_r != '0)
          || (count == '0)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end else if (k_r < count) begin
        chk_nxt = 1'b1; ck_nxt = k_r[IDX_W-1:0]; k_nxt = k_r + 1'b1;
      end else if (!chk_r) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; chk_r <= 1'b0; done_r <= 1'b0; found_r <= 1'b0;
      rel_r <= 1'b0; k_r <= '0;
    end else begin
      busy_r <= busy_nxt; chk_r <= chk_nxt; done_r <= done_nxt;
      found_r <= found_nxt; rel_r <= rel_nxt; k_r <= k_nxt;
    end
    ck_r <= ck_nxt; pick_r <= pick_nxt; plen_r <= plen_nxt;
  end
endmodule
`default_nettype wire

>>> bench/tb_segment_allocator_fit_policy.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_segment_allocator_fit_policy;
  import sega_pkg::*;

  localparam int NSEG  = 64;
  localparam int AW    = 20;
  localparam int IW    = 16;
  localparam int LW    = AW + 1;
  localparam int IN_W  = ((1 + IW + AW + 1 + 7) / 8) * 8;
  localparam int OUT_W = ((3 + 3 * AW + 2 + 7) / 8) * 8;
  localparam logic [LW-1:0] MEM_MAX = 21'h100000;
  localparam longint LIMIT = 2000000;

  // lowest field last: matches the word layout
  typedef struct packed {
    logic [LW-1:0] free_total;
    logic [LW-1:0] size;
    logic [AW-1:0] base;
    status_t       status;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_POLICY;
  logic [AW:0] cfg_wdata = '0;

  segment_allocator_fit_policy dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow allocator state
  logic [1:0]    pol;
  logic [AW-1:0] seg_base [NSEG];
  logic [LW-1:0] seg_len [NSEG];
  logic [IW-1:0] seg_own [NSEG];
  logic          seg_free [NSEG];
  int            seg_cnt;
  logic [LW-1:0] free_mem;

  grant_t grants_due[$];
  int errors = 0;
  longint cycles = 0;
  int out_lull = 0;   // 0 none, 1 short stalls, 2 some long

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("segment_allocator_fit_policy: mismatch");
      $finish;
    end
  end

  function automatic void rebuild(logic [LW-1:0] total);
    seg_base[0] = '0;
    seg_len[0]  = total;
    seg_free[0] = 1'b1;
    seg_own[0]  = '0;
    seg_cnt     = 1;
    free_mem    = total;
  endfunction

  function automatic void drop_entry(int idx);
    for (int k = idx; k + 1 < seg_cnt; k++) begin
      seg_base[k] = seg_base[k+1];
      seg_len[k]  = seg_len[k+1];
      seg_own[k]  = seg_own[k+1];
      seg_free[k] = seg_free[k+1];
    end
    seg_cnt--;
  endfunction

  function automatic grant_t serve(logic act, logic [IW-1:0] pid, logic [LW-1:0] sz);
    grant_t g;
    int pick;
    int k;
    g = '0;
    if (act == ACT_ALLOC) begin
      pick = -1;
      if (sz != 0) begin
        for (k = 0; k < seg_cnt; k++) begin
          if (!seg_free[k] || seg_len[k] < sz) continue;
          if (pick < 0) begin
            pick = k;
            if (pol != POL_WORST && pol != POL_BEST) break;
          end else if (pol == POL_WORST) begin
            if (seg_len[k] > seg_len[pick]) pick = k;
          end else if (seg_len[k] < seg_len[pick]) begin
            pick = k;
          end
        end
      end
      if (pick < 0) g.status = ST_NOFIT;
      else if (seg_len[pick] != sz && seg_cnt >= NSEG) g.status = ST_FULL;
      else begin
        if (seg_len[pick] != sz) begin
          for (k = seg_cnt; k > pick; k--) begin
            seg_base[k] = seg_base[k-1];
            seg_len[k]  = seg_len[k-1];
            seg_own[k]  = seg_own[k-1];
            seg_free[k] = seg_free[k-1];
          end
          seg_cnt++;
          seg_len[pick] = sz;
          seg_base[pick+1] = seg_base[pick] + sz[AW-1:0];
          seg_len[pick+1]  = seg_len[pick+1] - sz;
        end
        seg_free[pick] = 1'b0;
        seg_own[pick]  = pid;
        g.status = ST_ALLOC;
        g.base = seg_base[pick];
        g.size = sz;
        free_mem = free_mem - sz;
      end
    end else begin
      g.status = ST_NOID;
      for (k = 0; k < seg_cnt; k++)
        if (!seg_free[k] && seg_own[k] == pid) break;
      if (k < seg_cnt) begin
        g.status = ST_FREED;
        g.base = seg_base[k];
        g.size = seg_len[k];
        seg_free[k] = 1'b1;
        seg_own[k]  = '0;
        free_mem = free_mem + seg_len[k];
        if (k + 1 < seg_cnt && seg_free[k+1]) begin
          seg_len[k] = seg_len[k] + seg_len[k+1];
          drop_entry(k + 1);
        end
        if (k > 0 && seg_free[k-1]) begin
          seg_len[k-1] = seg_len[k-1] + seg_len[k];
          drop_entry(k);
        end
      end
    end
    g.free_total = free_mem;
    return g;
  endfunction

  // result checker with random back-pressure
  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[3+3*AW+1:0];
        if (grants_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", got);
        end else begin
          want = grants_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("exp st=%0d base=%h size=%h free=%h got st=%0d base=%h size=%h free=%h",
                want.status, want.base, want.size, want.free_total,
                got.status, got.base, got.size, got.free_total);
          end
        end
      end
      case (out_lull)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 15) != 0) ?
                   ($urandom_range(0, 2) != 0) : 1'b0;
      endcase
    end
  end

  // valid stays up between back-to-back words; it drops on a gap or in settle
  task automatic send_word(logic act, logic [IW-1:0] pid, logic [LW-1:0] sz, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({sz, pid, act});
    do @(posedge clk); while (!in_tready);
    grants_due.push_back(serve(act, pid, sz));
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 4);
  endfunction

  task automatic settle();
    in_tvalid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [AW:0] val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLICY) pol = val[1:0];
    else rebuild((val > MEM_MAX) ? MEM_MAX : val);
  endtask

  task automatic test_directed();
    send_word(ACT_ALLOC, 16'h0001, 21'd0, 0);          // zero size
    send_word(ACT_ALLOC, 16'hFFFF, 21'(MEM_MAX + 1), 0); // too big
    send_word(ACT_ALLOC, 16'h0001, 21'd100, 0);
    send_word(ACT_ALLOC, 16'h0002, 21'd50, 1);
    send_word(ACT_ALLOC, 16'h0001, 21'd30, 0);         // duplicate id
    send_word(ACT_ALLOC, 16'h0003, 21'd200, 0);
    send_word(ACT_RELEASE, 16'h0001, 21'h1FFFFF, 0);
    send_word(ACT_RELEASE, 16'h0003, 21'd0, 2);        // merges with trailing hole
    send_word(ACT_RELEASE, 16'h0003, 21'd0, 0);        // id gone
    send_word(ACT_RELEASE, 16'h0001, 21'd0, 0);        // merges with the hole above
    send_word(ACT_RELEASE, 16'h0002, 21'd0, 0);
    send_word(ACT_ALLOC, 16'h8000, MEM_MAX, 0);        // exact fit of whole range
    send_word(ACT_ALLOC, 16'h0004, 21'd1, 0);
    send_word(ACT_RELEASE, 16'h8000, 21'd0, 0);
  endtask

  task automatic test_table_full();
    int i;
    write_reg(CFG_TOTAL, 21'd200);
    for (i = 0; i < NSEG + 2; i++) send_word(ACT_ALLOC, i[IW-1:0], 21'd1, 0);
    send_word(ACT_ALLOC, 16'h0100, 21'(200 - NSEG + 1), 0);  // exact fit still works
    send_word(ACT_RELEASE, 16'd5, 21'd0, 0);
    send_word(ACT_ALLOC, 16'h0101, 21'd1, 0);
  endtask

  task automatic test_policy_ties();
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_TOTAL, 21'd1000);
      write_reg(CFG_POLICY, p[AW:0]);
      send_word(ACT_ALLOC, 16'd1, 21'd100, 0);
      send_word(ACT_ALLOC, 16'd2, 21'd10, 0);
      send_word(ACT_ALLOC, 16'd3, 21'd100, 0);
      send_word(ACT_ALLOC, 16'd4, 21'd10, 0);
      send_word(ACT_ALLOC, 16'd5, 21'd50, 0);
      send_word(ACT_ALLOC, 16'd6, 21'd10, 0);
      send_word(ACT_RELEASE, 16'd1, 21'd0, 0);
      send_word(ACT_RELEASE, 16'd3, 21'd0, 0);
      send_word(ACT_RELEASE, 16'd5, 21'd0, 0);
      send_word(ACT_ALLOC, 16'd7, 21'd40, 0);
      send_word(ACT_ALLOC, 16'd8, 21'd40, 0);
    end
  endtask

  task automatic test_odd_totals();
    write_reg(CFG_TOTAL, 21'h1FFFFF);                 // saturates
    send_word(ACT_ALLOC, 16'd9, MEM_MAX, 0);
    write_reg(CFG_TOTAL, 21'd0);
    send_word(ACT_ALLOC, 16'd9, 21'd1, 0);
    send_word(ACT_RELEASE, 16'd9, 21'd0, 0);
  endtask

  task automatic test_random(int n);
    logic [IW-1:0] live[$];
    logic [IW-1:0] pid;
    logic [LW-1:0] sz;
    int idx;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        write_reg(CFG_POLICY, 21'($urandom_range(0, 3)));
        write_reg(CFG_TOTAL, (i % 200 == 0) ? 21'd4096 : MEM_MAX);
        live.delete();
        out_lull = $urandom_range(0, 2);
      end
      if (live.size() != 0 && $urandom_range(0, 9) < 4) begin
        idx = $urandom_range(0, live.size() - 1);
        pid = live[idx];
        live.delete(idx);
        send_word(ACT_RELEASE, pid,
                  ($urandom_range(0, 9) == 0) ? 21'($urandom) : 21'd0, rand_gap());
      end else if ($urandom_range(0, 19) == 0) begin
        send_word(ACT_RELEASE, 16'($urandom), 21'($urandom), rand_gap());
      end else begin
        pid = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        case ($urandom_range(0, 9))
          0: sz = 21'($urandom);
          1: sz = 21'($urandom_range(1, 8));
          default: sz = 21'($urandom_range(1, 300)) << $urandom_range(0, 8);
        endcase
        live.push_back(pid);
        send_word(ACT_ALLOC, pid, sz, rand_gap());
      end
    end
  endtask

  initial begin
    pol = 2'd0;
    rebuild(MEM_MAX);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_policy_ties();
    test_odd_totals();
    out_lull = 2;
    test_random(270);
    settle();
    if (errors == 0) $display("segment_allocator_fit_policy: match");
    else $display("segment_allocator_fit_policy: mismatch");
    $finish;
  end
endmodule
`default_nettype wire
